/* hw/rtl/jue_pkg.sv */
// ----------------------------------------------------------------------------
// jue_pkg
// Types, character codes and encoding helpers shared by the escaper modules.
// ----------------------------------------------------------------------------
package jue_pkg;

    localparam int JOB_BYTES = 6;
    localparam int LEN_BITS  = 3;
    localparam int CAP_BITS  = 16;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 16'd256;

    localparam logic [1:0] MODE_RAW  = 2'd0;
    localparam logic [1:0] MODE_JSON = 2'd1;
    localparam logic [1:0] MODE_URL  = 2'd2;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOW_N   = 8'h6E;
    localparam logic [7:0] CH_LOW_R   = 8'h72;
    localparam logic [7:0] CH_LOW_T   = 8'h74;
    localparam logic [7:0] CH_LOW_B   = 8'h62;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [3:0] NIB_MASK   = 4'h0F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic [1:0] mode;
        logic       new_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       overflow;
    } t_out_item;

    // One classified input: the bytes to emit, how many, and the overflow mark.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [LEN_BITS-1:0]       len;
        logic                      ovf;
    } t_job;

    // Queue status seen by the front and back sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input logic upper);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = CH_ZERO + {4'd0, nib};
        end else begin
            d = (upper ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER ||
               c == CH_DOT || c == CH_TILDE;
    endfunction

    function automatic t_job expand(input logic [7:0] c, input logic [1:0] md);
        t_job       j;
        logic [7:0] short_c;
        j       = '0;
        short_c = 8'd0;
        j.bytes[0] = c;
        j.len      = 3'd1;
        if (md == MODE_JSON) begin
            unique case (c)
                CH_QUOTE:  short_c = CH_QUOTE;
                CH_BSLASH: short_c = CH_BSLASH;
                CH_LF:     short_c = CH_LOW_N;
                CH_CR:     short_c = CH_LOW_R;
                CH_TAB:    short_c = CH_LOW_T;
                CH_BS:     short_c = CH_LOW_B;
                CH_FF:     short_c = CH_LOW_F;
                default:   short_c = 8'd0;
            endcase
            if (short_c != 8'd0) begin
                j.bytes[0] = CH_BSLASH;
                j.bytes[1] = short_c;
                j.len      = 3'd2;
            end else if (c < CH_SPACE) begin
                j.bytes[0] = CH_BSLASH;
                j.bytes[1] = CH_LOW_U;
                j.bytes[2] = CH_ZERO;
                j.bytes[3] = CH_ZERO;
                j.bytes[4] = hex_digit(c[7:4] & NIB_MASK, 1'b0);
                j.bytes[5] = hex_digit(c[3:0] & NIB_MASK, 1'b0);
                j.len      = 3'd6;
            end
        end else if (md == MODE_URL) begin
            if (!is_unreserved(c)) begin
                j.bytes[0] = CH_PERCENT;
                j.bytes[1] = hex_digit(c[7:4], 1'b1);
                j.bytes[2] = hex_digit(c[3:0], 1'b1);
                j.len      = 3'd3;
            end
        end
        return j;
    endfunction

endpackage

/* hw/rtl/json_url_byte_escaper.sv */
// ----------------------------------------------------------------------------
// json_url_byte_escaper
// Byte-stream encoder: raw copy, JSON string escape or URL percent-encoding.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one source
//   byte, its mode and a new-buffer mark. A transfer happens at a clock edge
//   with valid high and stall low. Output channel (o_out_valid / i_out_stall
//   / o_out_item) carries one encoded byte per transfer, with last on the
//   final byte of each input and overflow on the single result that reports
//   a full buffer.
//   i_cfg_we / i_cfg_data write the output capacity; write only while idle.
// Timing:
//   The job for an item is written into the job queue at its input transfer;
//   its first output byte then goes into the back side's output register.
//   While the receiver does not stall, the back side emits one byte per cycle,
//   and an item expands to 1 byte (plain), 2 (short JSON escapes), 3 (%XX) or
//   6 (\u00xx); plain bytes stream at one per cycle. A four-entry job queue
//   decouples the sides, and the input stalls only when that queue is full.
// Reset:
//   Synchronous, active low: clears position count, overflow flag and queue,
//   and sets the capacity to 256. When the receiver stalls, the output byte
//   holds and the queue fills before the input stalls.
// ----------------------------------------------------------------------------
module json_url_byte_escaper import jue_pkg::*; #(
    parameter int POS_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_item,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_data
);

    logic    push, pop;
    t_job    job, head;
    t_q_stat q_stat;

    // Front: classify each byte, update position and sticky overflow.
    jue_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_item     (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (job)
    );

    // Hold classified jobs until the back side drains them.
    jue_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Back: emit the expansion one transfer at a time.
    jue_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_item      (o_out_item)
    );

    assign o_in_stall = q_stat.full;

endmodule

/* hw/rtl/jue_front.sv */
// ----------------------------------------------------------------------------
// jue_front
// Accepts input items, expands them and runs the buffer fit check.
// ----------------------------------------------------------------------------
module jue_front import jue_pkg::*; #(
    parameter int POS_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic [CAP_BITS-1:0] i_cfg_data,
    input  t_q_stat             i_q_stat,
    output logic                o_push,
    output t_job                o_job
);

    localparam int CMP_BITS = ((POS_BITS > CAP_BITS) ? POS_BITS : CAP_BITS) + 1;

    logic [CAP_BITS-1:0] r_cap;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic                r_ovf, n_ovf;

    logic [POS_BITS-1:0] eff_pos;
    logic                eff_ovf;
    t_job                exp_job;
    logic [CMP_BITS-1:0] need;
    logic                fits;

    always_comb begin
        eff_pos = i_item.new_buffer ? '0 : r_pos;
        eff_ovf = i_item.new_buffer ? 1'b0 : r_ovf;
        exp_job = expand(i_item.in_byte, i_item.mode);
        need    = CMP_BITS'(eff_pos) + CMP_BITS'(exp_job.len) + CMP_BITS'(1);
        fits    = !eff_ovf && (need <= CMP_BITS'(r_cap));
        o_push  = i_in_valid && !i_q_stat.full;
        if (fits) begin
            o_job = exp_job;
            n_pos = eff_pos + POS_BITS'(exp_job.len);
            n_ovf = 1'b0;
        end else begin
            o_job       = '0;
            o_job.len   = 3'd1;
            o_job.ovf   = 1'b1;
            n_pos       = eff_pos;
            n_ovf       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_pos <= '0;
            r_ovf <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (o_push) begin
                r_pos <= n_pos;
                r_ovf <= n_ovf;
            end
        end
    end

endmodule

/* hw/rtl/jue_queue.sv */
// ----------------------------------------------------------------------------
// jue_queue
// Short FIFO of classified jobs between the front and back sides.
// ----------------------------------------------------------------------------
module jue_queue import jue_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    localparam int DEPTH    = 4;
    localparam int PTR_BITS = $clog2(DEPTH);

    t_job                r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [PTR_BITS:0]   r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (PTR_BITS+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/jue_back.sv */
// ----------------------------------------------------------------------------
// jue_back
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
module jue_back import jue_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  t_q_stat   i_q_stat,
    output logic      o_pop,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_item
);

    logic [LEN_BITS-1:0] r_idx;
    logic                r_vld;
    t_out_item           r_item, n_item;
    logic                adv;
    logic                at_last;

    always_comb begin
        adv             = (!r_vld || !i_out_stall) && !i_q_stat.empty;
        at_last         = (r_idx == i_head.len - 1'b1);
        o_pop           = adv && at_last;
        n_item.out_byte = i_head.bytes[r_idx];
        n_item.last     = at_last;
        n_item.overflow = i_head.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else begin
            if (adv) begin
                r_vld <= 1'b1;
                r_idx <= at_last ? '0 : r_idx + 1'b1;
            end else if (!i_out_stall) begin
                r_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_vld;
    assign o_item      = r_item;

endmodule

/* hw/rtl/jue_checker.sv */
// ----------------------------------------------------------------------------
// jue_checker
// Port-level checks for the escaper, attached by bind.
// ----------------------------------------------------------------------------
module jue_checker import jue_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input t_out_item           o_out_item
);

    a_ovf_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.overflow |->
            o_out_item.last && o_out_item.out_byte == 8'd0)
        else $error("overflow result not a single zero byte");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output changed");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind json_url_byte_escaper jue_checker u_jue_checker (.*);

/* bench/tb_json_url_byte_escaper.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_url_byte_escaper
// Self-checking bench for the byte escaper. A driver process takes source
// bytes from a queue and offers them on the input channel. A scoreboard
// encodes every accepted byte into the bytes it should produce. A monitor
// checks every output transfer against the oldest pending byte. The run moves
// through several capacity settings and uses random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_json_url_byte_escaper;
    import jue_pkg::*;

    localparam int POS_W       = 16;
    localparam int STUCK_LIMIT = 3000;   // cycles with no transfer at all
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int MAX_PRINTS  = 40;

    // The block treats the unused mode code like a raw copy.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_item;
    logic                i_cfg_we;
    logic [CAP_BITS-1:0] i_cfg_data;

    // Scoreboard copy of the block state.
    logic [CAP_BITS-1:0] cap_model = CAP_RESET;
    logic [POS_W-1:0]    fill_count = '0;
    logic                ovf_sticky = 1'b0;

    t_in_item  source_q [$];     // bytes waiting to be offered
    t_out_item encoded_q [$];    // encoded bytes still owed by the block

    int err_count    = 0;
    int stuck_cycles = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    bit in_taken     = 1'b0;     // set at the edge that accepts an input transfer
    bit quiet        = 1'b0;     // no idling on either side while set
    bit hold_req     = 1'b0;     // ask the receiver for one long hold-off

    json_url_byte_escaper #(
        .POS_BITS (POS_W)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Scoreboard helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] nibble_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return (upper ? 8'h37 : 8'h57) + 8'(nib);
    endfunction

    // Characters a URL may carry unencoded.
    function automatic bit url_safe(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_UNDER ||
               c == CH_DOT || c == CH_TILDE;
    endfunction

    // Encode one accepted source byte and queue the bytes the block owes for it.
    task automatic encode_source(input t_in_item src);
        logic [7:0] seq [6];
        logic [7:0] esc;
        int         n;
        t_out_item  res;
        if (src.new_buffer) begin
            fill_count = '0;
            ovf_sticky = 1'b0;
        end
        seq[0] = src.in_byte;
        n      = 1;
        esc    = 8'h00;
        if (src.mode == MODE_JSON) begin
            case (src.in_byte)
                CH_QUOTE:  esc = CH_QUOTE;
                CH_BSLASH: esc = CH_BSLASH;
                CH_LF:     esc = CH_LOW_N;
                CH_CR:     esc = CH_LOW_R;
                CH_TAB:    esc = CH_LOW_T;
                CH_BS:     esc = CH_LOW_B;
                CH_FF:     esc = CH_LOW_F;
                default:   esc = 8'h00;
            endcase
            if (esc != 8'h00) begin
                seq[0] = CH_BSLASH;
                seq[1] = esc;
                n      = 2;
            end else if (src.in_byte < CH_SPACE) begin
                // Other control bytes: \u00xx with lowercase hex.
                seq[0] = CH_BSLASH;
                seq[1] = CH_LOW_U;
                seq[2] = CH_ZERO;
                seq[3] = CH_ZERO;
                seq[4] = nibble_char(src.in_byte[7:4], 1'b0);
                seq[5] = nibble_char(src.in_byte[3:0], 1'b0);
                n      = 6;
            end
        end else if (src.mode == MODE_URL && !url_safe(src.in_byte)) begin
            seq[0] = CH_PERCENT;
            seq[1] = nibble_char(src.in_byte[7:4], 1'b1);
            seq[2] = nibble_char(src.in_byte[3:0], 1'b1);
            n      = 3;
        end
        // One byte of the buffer stays reserved for the terminator.
        if (ovf_sticky || int'(fill_count) + n + 1 > int'(cap_model)) begin
            ovf_sticky   = 1'b1;
            res.out_byte = 8'h00;
            res.last     = 1'b1;
            res.overflow = 1'b1;
            encoded_q.push_back(res);
        end else begin
            for (int k = 0; k < n; k++) begin
                res.out_byte = seq[k];
                res.last     = (k == n - 1);
                res.overflow = 1'b0;
                encoded_q.push_back(res);
            end
            fill_count = fill_count + POS_W'(n);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS) begin
            $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
        end
        err_count++;
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Bias bytes toward the ones that escape: control bytes and punctuation.
    function automatic logic [7:0] pick_byte();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: c = 8'($urandom_range(0, 31));
            2: begin
                case ($urandom_range(0, 6))
                    0:       c = CH_QUOTE;
                    1:       c = CH_BSLASH;
                    2:       c = CH_DASH;
                    3:       c = CH_UNDER;
                    4:       c = CH_DOT;
                    5:       c = CH_TILDE;
                    default: c = CH_PERCENT;
                endcase
            end
            3, 4, 5: c = 8'($urandom_range(32, 126));
            default: c = 8'($urandom);
        endcase
        return c;
    endfunction

    // Random source byte; a new buffer starts about once in nb_odds bytes.
    function automatic t_in_item make_source(input int nb_odds);
        t_in_item src;
        int       r;
        src.in_byte    = pick_byte();
        src.new_buffer = ($urandom_range(0, nb_odds - 1) == 0);
        r = $urandom_range(0, 9);
        if (r < 2) begin
            src.mode = MODE_RAW;
        end else if (r < 6) begin
            src.mode = MODE_JSON;
        end else if (r < 9) begin
            src.mode = MODE_URL;
        end else begin
            src.mode = MODE_SPARE;
        end
        return src;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: change at the falling edge, hold the payload while stalled.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_source
        logic     nxt_valid;
        t_in_item nxt_item;
        nxt_valid = i_in_valid;
        nxt_item  = i_in_item;
        // Drop the byte that went across at the last rising edge.
        if (in_taken) begin
            in_taken  = 1'b0;
            nxt_valid = 1'b0;
            send_gap  = quiet ? 0 : gap_len();
        end
        if (!nxt_valid && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (source_q.size() != 0) begin
                nxt_item  = source_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        // Exactly one nonblocking update per signal, so a back-to-back
        // transfer keeps valid high without a glitch.
        i_in_valid <= nxt_valid;
        i_in_item  <= nxt_item;
    end

    // ------------------------------------------------------------------
    // Output stall: random bursts, plus one long hold-off on request that
    // is counted here so the sender keeps offering bytes meanwhile.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_stall
        logic nxt_stall;
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            nxt_stall = 1'b1;
            hold_left--;
            if (hold_left == 0) begin
                hold_req = 1'b0;
            end
        end else if (stall_left > 0) begin
            nxt_stall = 1'b1;
            stall_left--;
        end else begin
            nxt_stall  = 1'b0;
            stall_left = quiet ? 0 : gap_len();
        end
        i_out_stall <= nxt_stall;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        t_out_item want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            encode_source(i_in_item);
            in_taken = 1'b1;
            moved    = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            moved = 1'b1;
            if (encoded_q.size() == 0) begin
                report_mismatch("output transfer with nothing owed, byte", o_out_item.out_byte, 0);
            end else begin
                want = encoded_q.pop_front();
                if (o_out_item.out_byte !== want.out_byte) begin
                    report_mismatch("out_byte", o_out_item.out_byte, want.out_byte);
                end
                if (o_out_item.last !== want.last) begin
                    report_mismatch("last", o_out_item.last, want.last);
                end
                if (o_out_item.overflow !== want.overflow) begin
                    report_mismatch("overflow", o_out_item.overflow, want.overflow);
                end
            end
        end
        if (moved || i_cfg_we) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
    end

    initial begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    task automatic queue_source(input logic [7:0] c, input logic [1:0] md, input logic nb);
        t_in_item src;
        src.in_byte    = c;
        src.mode       = md;
        src.new_buffer = nb;
        source_q.push_back(src);
    endtask

    // Wait until every byte is sent and every owed byte has come back,
    // then give the pipeline time to settle.
    task automatic drain_all();
        while (source_q.size() != 0 || i_in_valid || encoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // Only called with the block idle.
    task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cap_model = cap;
    endtask

    // Random bytes in chunks; after some chunks the sender waits until the
    // block has delivered everything it owes.
    task automatic run_random(input int count, input int nb_odds);
        for (int k = 0; k < count; k++) begin
            source_q.push_back(make_source(nb_odds));
            if (k % 25 == 24) begin
                while (source_q.size() != 0) begin
                    @(posedge i_clk);
                end
                if ($urandom_range(0, 2) == 0) begin
                    while (i_in_valid || encoded_q.size() != 0) begin
                        @(posedge i_clk);
                    end
                end
            end
        end
        while (source_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass at the reset capacity: every mode and escape class.
        set_capacity(CAP_RESET);
        queue_source(8'h00,     MODE_RAW,   1'b1);
        queue_source(8'hFF,     MODE_RAW,   1'b0);
        queue_source(8'h41,     MODE_SPARE, 1'b0);
        queue_source(CH_QUOTE,  MODE_JSON,  1'b0);
        queue_source(CH_BSLASH, MODE_JSON,  1'b0);
        queue_source(CH_LF,     MODE_JSON,  1'b0);
        queue_source(CH_CR,     MODE_JSON,  1'b0);
        queue_source(CH_TAB,    MODE_JSON,  1'b0);
        queue_source(CH_BS,     MODE_JSON,  1'b0);
        queue_source(CH_FF,     MODE_JSON,  1'b0);
        queue_source(8'h00,     MODE_JSON,  1'b0);
        queue_source(8'h1F,     MODE_JSON,  1'b0);
        queue_source(8'h7F,     MODE_JSON,  1'b0);
        queue_source(8'hFF,     MODE_JSON,  1'b0);
        queue_source(8'h41,     MODE_URL,   1'b0);
        queue_source(8'h7A,     MODE_URL,   1'b0);
        queue_source(8'h30,     MODE_URL,   1'b0);
        queue_source(8'h39,     MODE_URL,   1'b0);
        queue_source(CH_DASH,   MODE_URL,   1'b0);
        queue_source(CH_UNDER,  MODE_URL,   1'b0);
        queue_source(CH_DOT,    MODE_URL,   1'b0);
        queue_source(CH_TILDE,  MODE_URL,   1'b0);
        queue_source(CH_SPACE,  MODE_URL,   1'b0);
        queue_source(8'h00,     MODE_URL,   1'b0);
        queue_source(8'hFF,     MODE_URL,   1'b0);
        drain_all();

        // Capacity edge: a six-byte escape that exactly fills the buffer,
        // then a sticky overflow, a fresh buffer, and a fill up to the limit.
        set_capacity(16'd7);
        queue_source(8'h01,    MODE_JSON, 1'b1);
        queue_source(8'h61,    MODE_RAW,  1'b0);
        queue_source(CH_SPACE, MODE_URL,  1'b0);
        queue_source(8'h62,    MODE_RAW,  1'b1);
        queue_source(8'h00,    MODE_URL,  1'b0);
        queue_source(CH_LF,    MODE_JSON, 1'b0);
        queue_source(8'h63,    MODE_RAW,  1'b0);
        drain_all();

        // Zero and one: nothing fits at all.
        set_capacity(16'd0);
        queue_source(8'h41, MODE_RAW,  1'b1);
        queue_source(CH_LF, MODE_JSON, 1'b1);
        drain_all();
        set_capacity(16'd1);
        queue_source(8'h41,    MODE_RAW, 1'b1);
        queue_source(CH_SPACE, MODE_URL, 1'b0);
        drain_all();

        // Largest capacity under back pressure: hold the receiver off while
        // the sender keeps going, so the job queue fills and stalls input.
        set_capacity(16'hFFFF);
        for (int k = 0; k < 150; k++) begin
            source_q.push_back(make_source(50));
        end
        hold_req = 1'b1;
        while (source_q.size() != 0) begin
            @(posedge i_clk);
        end
        drain_all();

        // Small buffers so overflow and new-buffer recovery happen often;
        // the first one runs with no idling on either side.
        quiet = 1'b1;
        set_capacity(16'd24);
        run_random(75, 8);
        drain_all();
        quiet = 1'b0;

        set_capacity(16'd12);
        run_random(75, 6);
        drain_all();

        set_capacity(16'($urandom_range(2, 64)));
        run_random(100, 10);
        drain_all();

        set_capacity(CAP_RESET);
        run_random(100, 40);
        drain_all();

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
